/* rtl/lasso_point_in_polygon_select_unit_macros.svh */
// assertion macros for the lasso point-in-polygon select unit
// used by the top level only, no other dependencies
`ifndef LASSO_POINT_IN_POLYGON_SELECT_UNIT_MACROS_SVH
`define LASSO_POINT_IN_POLYGON_SELECT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPIP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpip assertion failed");

// next-cycle implication, disabled during reset
`define LPIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpip assertion failed");

`endif

/* rtl/lpip_pkg.sv */
// shared constants, operation codes and controller/datapath structs
// no dependencies
`default_nettype none

package lpip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int OP_W         = 2;
  localparam int COORD_W      = 18;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int IDX_W        = 20;
  localparam int COUNT_W      = 21;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1048576);

  // operation codes of an input transaction
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PASS   = 2'd2,
    OP_TEST   = 2'd3
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic               clear_lasso;
    logic               append;
    logic               clear_count;
    logic               start_test;
    logic               rd_en;
    logic               rd_first;
    logic [VADDR_W-1:0] rd_addr;
    logic               load_out;
  } lpip_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [VCNT_W-1:0] vertex_count;
    logic              pipe_busy;
  } lpip_sts_t;

endpackage

`default_nettype wire

/* rtl/lpip_in_if.sv */
// input channel: operation, coordinates and point index with valid/ready
// depends on lpip_pkg
`default_nettype none

interface lpip_in_if;
  logic                                valid;
  logic                                ready;
  logic [lpip_pkg::OP_W-1:0]           op;
  logic signed [lpip_pkg::COORD_W-1:0] coord_x;
  logic signed [lpip_pkg::COORD_W-1:0] coord_y;
  logic [lpip_pkg::IDX_W-1:0]          point_index;

  modport source (output valid, op, coord_x, coord_y, point_index, input ready);
  modport sink   (input valid, op, coord_x, coord_y, point_index, output ready);
endinterface

`default_nettype wire

/* rtl/lpip_out_if.sv */
// result channel: point index, inside and active flags, active count
// depends on lpip_pkg
`default_nettype none

interface lpip_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpip_pkg::IDX_W-1:0]   result_index;
  logic                         inside_res;
  logic                         active;
  logic [lpip_pkg::COUNT_W-1:0] active_count;

  modport source (output valid, result_index, inside_res, active, active_count,
                  input ready);
  modport sink   (input valid, result_index, inside_res, active, active_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/lpip_datapath.sv */
// datapath: vertex memory, edge crossing pipeline, parity, counters, result register
// depends on lpip_pkg
`default_nettype none

module lpip_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lpip_pkg::lpip_cmd_t                 cmd,
  output lpip_pkg::lpip_sts_t                 sts,
  input  logic signed [lpip_pkg::COORD_W-1:0] coord_x,
  input  logic signed [lpip_pkg::COORD_W-1:0] coord_y,
  input  logic [lpip_pkg::IDX_W-1:0]          point_index,
  output logic [lpip_pkg::IDX_W-1:0]          result_index,
  output logic                                inside_res,
  output logic                                active,
  output logic [lpip_pkg::COUNT_W-1:0]        active_count
);

  // vertex memory, one write and one registered read port
  logic signed [lpip_pkg::COORD_W-1:0] vx_mem [lpip_pkg::MAX_VERTICES];
  logic signed [lpip_pkg::COORD_W-1:0] vy_mem [lpip_pkg::MAX_VERTICES];

  logic [lpip_pkg::VCNT_W-1:0]         vertex_count;
  logic [lpip_pkg::COUNT_W-1:0]        active_total;
  logic [lpip_pkg::COUNT_W-1:0]        active_total_next;
  logic                                count_hit;
  logic                                append_ok;

  logic signed [lpip_pkg::COORD_W-1:0] px, py;
  logic [lpip_pkg::IDX_W-1:0]          pidx;

  logic                                rd_vld, rd_first;
  logic signed [lpip_pkg::COORD_W-1:0] rd_x, rd_y;
  logic signed [lpip_pkg::COORD_W-1:0] prev_x, prev_y;

  logic                                edge_vld;
  logic                                s2_vld, s2_cross;
  logic signed [lpip_pkg::DIFF_W-1:0]  s2_dy, s2_dpx, s2_dbx, s2_dpy;
  logic                                s3_vld, s3_dpos;
  logic signed [lpip_pkg::PROD_W-1:0]  s3_lhs, s3_rhs;
  logic                                s3_left;
  logic                                parity;

  assign append_ok = cmd.append &&
                     (vertex_count < lpip_pkg::VCNT_W'(lpip_pkg::MAX_VERTICES));

  // vertex store and read
  always_ff @(posedge clk) begin
    if (append_ok) begin
      vx_mem[vertex_count[lpip_pkg::VADDR_W-1:0]] <= coord_x;
      vy_mem[vertex_count[lpip_pkg::VADDR_W-1:0]] <= coord_y;
    end
    if (cmd.rd_en) begin
      rd_x <= vx_mem[cmd.rd_addr];
      rd_y <= vy_mem[cmd.rd_addr];
    end
  end

  // vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cmd.clear_lasso) begin
      vertex_count <= '0;
    end else if (append_ok) begin
      vertex_count <= vertex_count + lpip_pkg::VCNT_W'(1);
    end
  end

  // test point capture
  always_ff @(posedge clk) begin
    if (cmd.start_test) begin
      px   <= coord_x;
      py   <= coord_y;
      pidx <= point_index;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      s2_vld <= edge_vld;
      s3_vld <= s2_vld && s2_cross;
    end
  end

  assign edge_vld = rd_vld && !rd_first;

  // edge start vertex follows the read stream
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_first <= cmd.rd_first;
    end
    if (rd_vld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  // straddle check and differences, edge runs from prev to current vertex
  always_ff @(posedge clk) begin
    s2_cross <= (prev_y > py) != (rd_y > py);
    s2_dy    <= lpip_pkg::DIFF_W'(rd_y)   - lpip_pkg::DIFF_W'(prev_y);
    s2_dpx   <= lpip_pkg::DIFF_W'(px)     - lpip_pkg::DIFF_W'(prev_x);
    s2_dbx   <= lpip_pkg::DIFF_W'(rd_x)   - lpip_pkg::DIFF_W'(prev_x);
    s2_dpy   <= lpip_pkg::DIFF_W'(py)     - lpip_pkg::DIFF_W'(prev_y);
  end

  // cross products
  always_ff @(posedge clk) begin
    s3_dpos <= !s2_dy[lpip_pkg::DIFF_W-1];
    s3_lhs  <= lpip_pkg::PROD_W'(s2_dpx) * lpip_pkg::PROD_W'(s2_dy);
    s3_rhs  <= lpip_pkg::PROD_W'(s2_dbx) * lpip_pkg::PROD_W'(s2_dpy);
  end

  // sign-corrected compare replaces the division
  assign s3_left = s3_dpos ? (s3_lhs < s3_rhs) : (s3_lhs > s3_rhs);

  // even-odd parity
  always_ff @(posedge clk) begin
    if (cmd.start_test) begin
      parity <= 1'b0;
    end else if (s3_vld && s3_left) begin
      parity <= !parity;
    end
  end

  // saturating active count, not counted with an empty lasso
  assign count_hit = (vertex_count != '0) && parity && (active_total < lpip_pkg::COUNT_LIMIT);
  assign active_total_next = count_hit ? active_total + lpip_pkg::COUNT_W'(1) : active_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_total <= '0;
    end else if (cmd.clear_count) begin
      active_total <= '0;
    end else if (cmd.load_out) begin
      active_total <= active_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_index <= pidx;
      inside_res   <= parity;
      active       <= (vertex_count == '0) || parity;
      active_count <= active_total_next;
    end
  end

  assign sts.vertex_count = vertex_count;
  assign sts.pipe_busy    = rd_vld || s2_vld || s3_vld;

endmodule

`default_nettype wire

/* rtl/lpip_ctrl.sv */
// controller: transaction decode, edge walk sequencing and result handshake
// depends on lpip_pkg
`default_nettype none

module lpip_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lpip_pkg::OP_W-1:0] op,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lpip_pkg::lpip_cmd_t       cmd,
  input  lpip_pkg::lpip_sts_t       sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [lpip_pkg::VCNT_W-1:0] rd_idx, rd_idx_next;
  logic                        accept;
  logic                        walk_last;
  logic                        out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign walk_last = (rd_idx == sts.vertex_count);
  assign out_free  = !out_valid || out_ready;

  // command decode and next state
  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    cmd             = '0;
    cmd.clear_lasso = accept && (op == lpip_pkg::OP_CLEAR);
    cmd.append      = accept && (op == lpip_pkg::OP_APPEND);
    cmd.clear_count = accept && (op == lpip_pkg::OP_PASS);
    cmd.start_test  = accept && (op == lpip_pkg::OP_TEST);
    unique case (state)
      S_IDLE: begin
        rd_idx_next = '0;
        if (cmd.start_test) begin
          state_next = (sts.vertex_count == '0) ? S_FINISH : S_WALK;
        end
      end
      // read vertices 0..n-1 then vertex 0 again to close the polygon
      S_WALK: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (rd_idx == '0);
        cmd.rd_addr  = walk_last ? '0 : rd_idx[lpip_pkg::VADDR_W-1:0];
        if (walk_last) begin
          state_next = S_DRAIN;
        end else begin
          rd_idx_next = rd_idx + lpip_pkg::VCNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, walk counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lasso_point_in_polygon_select_unit.sv */
// Lasso point-in-polygon select unit, top level.
// Input channel "item" carries op, coord_x, coord_y and point_index (signed Q2.16
// coordinates). Op clear lasso empties the polygon, append vertex stores one
// vertex (ignored once 64 are held), start pass zeroes the active count; each
// produces no result. Test point walks every closed edge of the stored
// polygon and returns one transaction on channel "result" with result_index,
// inside_res, active and the saturating active_count. A test point with n
// vertices makes n + 1 memory reads through a single read port, then drains
// the edge pipeline and loads the result; with no vertices it goes straight
// to the result load. One test point is worked at a time and the next
// transaction is taken the cycle after the result load.
// A result waiting in the output register does not block new transactions; a
// finished test waits only if the previous result has not yet been taken.
// Synchronous reset empties the polygon, zeroes the count and drops result
// valid; vertex memory contents are not cleared and need no clearing pass.
// depends on lpip_pkg, lpip_in_if, lpip_out_if, lpip_ctrl, lpip_datapath
`default_nettype none

`include "lasso_point_in_polygon_select_unit_macros.svh"

module lasso_point_in_polygon_select_unit (
  input  logic       clk,
  input  logic       rst,
  lpip_in_if.sink    item,
  lpip_out_if.source result
);

  lpip_pkg::lpip_cmd_t cmd;
  lpip_pkg::lpip_sts_t sts;

  // sequencing
  lpip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .op        (item.op),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and arithmetic
  lpip_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .coord_x      (item.coord_x),
    .coord_y      (item.coord_y),
    .point_index  (item.point_index),
    .result_index (result.result_index),
    .inside_res   (result.inside_res),
    .active       (result.active),
    .active_count (result.active_count)
  );

  // result register is only overwritten once free, and only after the edge pipeline drained
  `LPIP_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, !result.valid || result.ready)
  `LPIP_ASSERT_IMP(a_load_pipe_idle, clk, rst, cmd.load_out, !sts.pipe_busy)
  // an inside point is always active
  `LPIP_ASSERT_IMP(a_inside_active, clk, rst, result.valid && result.inside_res, result.active)
  // vertex reads only happen while no new transaction is taken
  `LPIP_ASSERT_NEXT(a_read_blocks_input, clk, rst, cmd.rd_en, !item.ready || !sts.pipe_busy)

endmodule

`default_nettype wire

/* sim/lpip_selection_checker.sv */
// selection checker for the lasso point-in-polygon select unit
// watches the item and result channels; depends on lpip_pkg, lpip_in_if, lpip_out_if
module lpip_selection_checker (
  input  logic clk,
  input  logic rst,
  lpip_in_if   item,
  lpip_out_if  result,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lpip_pkg::*;

  // one predicted selection result
  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic               inside_flag;
    logic               active_flag;
    logic [COUNT_W-1:0] count;
  } selection_t;

  // own copy of the lasso and the pass count
  logic signed [COORD_W-1:0] lasso_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] lasso_y [MAX_VERTICES];
  int                        vertex_total;
  logic [COUNT_W-1:0]        active_total;
  selection_t                expected_selections [$];
  int                        mismatches;

  // even-odd crossing test over every closed edge, exact cross-multiplication
  function automatic bit lasso_encloses(longint px, longint py);
    bit     parity;
    bit     left;
    int     b;
    longint ax, ay, bx, by, d, lhs, rhs;
    parity = 1'b0;
    for (int a = 0; a < vertex_total; a++) begin
      b  = (a + 1 < vertex_total) ? a + 1 : 0;
      ax = lasso_x[a];
      ay = lasso_y[a];
      bx = lasso_x[b];
      by = lasso_y[b];
      if ((ay > py) != (by > py)) begin
        d    = by - ay;
        lhs  = (px - ax) * d;
        rhs  = (bx - ax) * (py - ay);
        left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left)
          parity = !parity;
      end
    end
    return parity;
  endfunction

  task automatic log_mismatch(string cause, selection_t want, selection_t seen);
    if (mismatches < 10)
      $display("%0t %s: exp idx %h in %b act %b cnt %0d, got idx %h in %b act %b cnt %0d",
               $time, cause, want.index, want.inside_flag, want.active_flag, want.count,
               seen.index, seen.inside_flag, seen.active_flag, seen.count);
    mismatches++;
  endtask

  always @(posedge clk) begin
    selection_t seen;
    selection_t want;
    selection_t predicted;
    bit         inside_f;
    bit         active_f;
    if (rst) begin
      vertex_total = 0;
      active_total = '0;
      expected_selections.delete();
      mismatches = 0;
    end else begin
      // compare a result transaction with the oldest prediction
      if (result.valid && result.ready) begin
        seen = '{result.result_index, result.inside_res, result.active, result.active_count};
        if (expected_selections.size() == 0) begin
          log_mismatch("unexpected result", '0, seen);
        end else begin
          want = expected_selections.pop_front();
          if (seen !== want)
            log_mismatch("result mismatch", want, seen);
        end
      end
      // update the lasso state and predict on an item transaction
      if (item.valid && item.ready) begin
        case (op_t'(item.op))
          OP_CLEAR: begin
            vertex_total = 0;
          end
          OP_APPEND: begin
            if (vertex_total < MAX_VERTICES) begin
              lasso_x[vertex_total] = item.coord_x;
              lasso_y[vertex_total] = item.coord_y;
              vertex_total++;
            end
          end
          OP_PASS: begin
            active_total = '0;
          end
          OP_TEST: begin
            if (vertex_total == 0) begin
              // no lasso: active but not counted
              inside_f = 1'b0;
              active_f = 1'b1;
            end else begin
              inside_f = lasso_encloses(item.coord_x, item.coord_y);
              active_f = inside_f;
              if (active_f && active_total < COUNT_LIMIT)
                active_total++;
            end
            predicted = '{item.point_index, inside_f, active_f, active_total};
            expected_selections = {expected_selections, predicted};
          end
          default: ;
        endcase
      end
    end
    errors      <= mismatches;
    outstanding <= expected_selections.size();
  end

endmodule

/* sim/lasso_point_in_polygon_select_unit_tb.sv */
// testbench top for the lasso point-in-polygon select unit: clock, reset, stimulus, verdict
// depends on lpip_pkg, lpip_in_if, lpip_out_if, lpip_selection_checker and the unit itself
module lasso_point_in_polygon_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpip_pkg::*;

  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));
  localparam int IDX_MAX     = (1 << IDX_W) - 1;
  localparam int ITEM_TARGET = 900;
  localparam int CALM_AFTER  = 800;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   cycles;

  lpip_in_if  item_ch ();
  lpip_out_if result_ch ();

  lasso_point_in_polygon_select_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  lpip_selection_checker checker_u (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // stimulus-side view of the lasso, used only to pick interesting points
  int stim_x [MAX_VERTICES];
  int stim_y [MAX_VERTICES];
  int held;
  int items_sent;
  bit calm;
  bit gappy;
  int stall_left;
  int quiet_left;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result back-pressure: bursts of stalls and quiet stretches
  always @(posedge clk) begin
    if (rst || calm) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (quiet_left > 0) begin
      result_ch.ready <= 1'b1;
      quiet_left      <= quiet_left - 1;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          result_ch.ready <= 1'b0;
          stall_left      <= $urandom_range(0, 18);
        end
        1: begin
          result_ch.ready <= 1'b1;
          quiet_left      <= $urandom_range(50, 300);
        end
        default: result_ch.ready <= 1'b1;
      endcase
    end
  end

  // coordinate near a centre, on a coarse grid or anywhere within the span
  function automatic int coord_near(int centre, int span, bit grid);
    int v;
    if (grid)
      v = centre + (int'($urandom_range(0, 8)) - 4) * (span / 4);
    else
      v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v > COORD_MAX)
      v = COORD_MAX;
    if (v < COORD_MIN)
      v = COORD_MIN;
    return v;
  endfunction

  function automatic int unsigned pick_index();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return IDX_MAX;
      default: return $urandom_range(0, IDX_MAX);
    endcase
  endfunction

  // drive one item transaction and wait for its acceptance
  task automatic push_item(input op_t op, input int x, input int y, input int unsigned idx);
    bit ignored;
    ignored = (op == OP_APPEND) && (held >= MAX_VERTICES);
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= op;
    item_ch.coord_x     <= x[COORD_W-1:0];
    item_ch.coord_y     <= y[COORD_W-1:0];
    item_ch.point_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (!item_ch.ready);
    case (op)
      OP_CLEAR: held = 0;
      OP_APPEND: begin
        if (!ignored) begin
          stim_x[held] = x;
          stim_y[held] = y;
          held++;
        end
      end
      default: ;
    endcase
    if (!ignored)
      items_sent++;
  endtask

  initial begin
    int n, k, span, cx, cy, px, py, vy, pick;
    bit grid, fresh, paused;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.op          = OP_CLEAR;
    item_ch.coord_x     = '0;
    item_ch.coord_y     = '0;
    item_ch.point_index = '0;
    result_ch.ready     = 1'b0;
    cycles              = 0;
    stall_left          = 0;
    quiet_left          = 0;
    held                = 0;
    items_sent          = 0;
    calm                = 1'b0;
    gappy               = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty lasso, degenerate lassos, extremes, count behaviour
    push_item(OP_TEST,   COORD_MIN, COORD_MIN, 0);
    push_item(OP_PASS,   0, 0, 0);
    push_item(OP_APPEND, 0, 0, 0);
    push_item(OP_TEST,   0, 0, IDX_MAX);
    push_item(OP_APPEND, 65536, 65536, 0);
    push_item(OP_TEST,   32768, 32768, 1);
    push_item(OP_CLEAR,  0, 0, 0);
    push_item(OP_APPEND, COORD_MIN, COORD_MIN, 0);
    push_item(OP_APPEND, COORD_MAX, COORD_MIN, 0);
    push_item(OP_APPEND, 0, COORD_MAX, 0);
    push_item(OP_TEST,   0, 0, 2);
    push_item(OP_TEST,   COORD_MIN, COORD_MIN, 3);
    // point level with a horizontal edge
    push_item(OP_TEST,   0, COORD_MIN, 4);
    push_item(OP_TEST,   COORD_MAX, COORD_MAX, 5);
    push_item(OP_PASS,   0, 0, 0);
    push_item(OP_TEST,   0, 0, 6);
    // clearing the lasso keeps the count
    push_item(OP_CLEAR,  0, 0, 0);
    push_item(OP_TEST,   5, 5, 7);
    push_item(OP_APPEND, 0, 0, 0);
    push_item(OP_APPEND, 65536, 0, 0);
    push_item(OP_APPEND, 65536, 65536, 0);
    push_item(OP_APPEND, 0, 65536, 0);
    // points exactly on vertical and horizontal edges
    push_item(OP_TEST,   0, 32768, 8);
    push_item(OP_TEST,   65536, 32768, 9);
    push_item(OP_TEST,   32768, 65536, 10);

    // random lasso sessions: build a polygon, start a pass, test points
    fresh  = 1'b1;
    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      calm  = items_sent >= CALM_AFTER;
      gappy = $urandom_range(0, 2) != 0;
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        // let the unit drain completely once
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (fresh)
        n = MAX_VERTICES + 6;
      else if (pick < 4)
        n = 0;
      else if (pick < 10)
        n = $urandom_range(1, 2);
      else if (pick < 92)
        n = $urandom_range(3, 8);
      else
        n = $urandom_range(40, MAX_VERTICES + 6);
      grid = $urandom_range(0, 2) == 0;
      span = 1 << $urandom_range(2, COORD_W - 1);
      cx   = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      cy   = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;

      // usually a fresh lasso, sometimes appended onto the old one
      if (fresh || $urandom_range(0, 7) != 0)
        push_item(OP_CLEAR, 0, 0, pick_index());
      vy = coord_near(cy, span, grid);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) != 0)
          vy = coord_near(cy, span, grid);
        push_item(OP_APPEND, coord_near(cx, span, grid), vy, pick_index());
      end
      if ($urandom_range(0, 5) != 0)
        push_item(OP_PASS, 0, 0, pick_index());

      k = $urandom_range(3, 14);
      for (int j = 0; j < k; j++) begin
        // occasional noise transaction with fully random fields
        if ($urandom_range(0, 19) == 0)
          push_item(op_t'($urandom_range(0, 3)),
                    int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN,
                    int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN, pick_index());
        pick = $urandom_range(0, 19);
        if (held > 0 && pick < 3) begin
          // on a vertex level, or on the vertex itself
          vy = $urandom_range(0, held - 1);
          py = stim_y[vy];
          px = (pick == 0) ? stim_x[vy] : coord_near(cx, span, grid);
        end else if (pick < 6) begin
          px = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
          py = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
        end else begin
          px = coord_near(cx, span, grid);
          py = coord_near(cy, span, grid);
        end
        push_item(OP_TEST, px, py, pick_index());
      end
      fresh = 1'b0;
    end

    // drain and allow for any late result
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (MAX_VERTICES + 16) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* lasso_point_in_polygon_select_unit.f */
+incdir+rtl
rtl/lpip_pkg.sv
rtl/lpip_in_if.sv
rtl/lpip_out_if.sv
rtl/lpip_datapath.sv
rtl/lpip_ctrl.sv
rtl/lasso_point_in_polygon_select_unit.sv
sim/lpip_selection_checker.sv
sim/lasso_point_in_polygon_select_unit_tb.sv
